### rtl/lpht_pkg.sv
// Shared types and constants for the linear probing hash table.
package lpht_pkg;

    localparam int KeyW  = 31;
    localparam int ValW  = 32;
    localparam int SlotW = 4;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FULL = 1'b1;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_HASH  = 5'b00100,
        S_PROBE = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

endpackage

### rtl/linear_probe_hash_table.sv
// Linear probing hash table top level: hash, probe sequencer and result register.
// Power-of-two TABLE_SLOTS: the home slot is the low key bits; a request takes 1..N probes.
// Other sizes first get the home slot from a key mod unit, a quotient step then a subtract step per key byte.
// Flow: one request at a time; o_ready rises with o_valid, and a result left waiting
// holds the done state.
// Reset (synchronous, active low) starts a clearing pass over the used bits;
// o_ready stays low until it ends.
module linear_probe_hash_table
    import lpht_pkg::*;
#(
    parameter int TABLE_SLOTS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic                   i_op,
    input  logic [KeyW-1:0]        i_key,
    input  logic signed [ValW-1:0] i_value,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic                   o_found,
    output logic signed [ValW-1:0] o_found_value,
    output logic [SlotW-1:0]       o_slot,
    output logic                   o_status
);

    localparam int  AW     = $clog2(TABLE_SLOTS);
    localparam bit  IsPow2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
    localparam logic [AW-1:0] LastSlot = AW'(TABLE_SLOTS - 1);

    // Key mod unit: fold in one key byte per step with a reciprocal multiply.
    localparam int ChunkW     = 8;
    localparam int NumChunks  = (KeyW + ChunkW - 1) / ChunkW;
    localparam int KeyPadW    = NumChunks * ChunkW;
    localparam int HcW        = $clog2(NumChunks);
    localparam int XW         = AW + ChunkW;
    localparam int MW         = AW + ChunkW + 2;
    localparam int QW         = ChunkW + 1;
    localparam int RecipShift = 2 * AW + ChunkW;
    localparam longint RecipM = (longint'(1) << RecipShift) / TABLE_SLOTS + 1;
    localparam logic [MW-1:0] RecipMul = MW'(RecipM);
    localparam logic [XW-1:0] ModX     = XW'(TABLE_SLOTS);

    t_state                 r_state, n_state;
    logic [AW-1:0]          r_pos, n_pos;
    logic [AW-1:0]          r_cnt, n_cnt;
    logic [AW-1:0]          r_rem, n_rem;
    logic [HcW-1:0]         r_hcnt, n_hcnt;
    logic                   r_hphase, n_hphase;
    logic [QW-1:0]          r_hq, n_hq;
    logic                   r_op, n_op;
    logic [KeyW-1:0]        r_key, n_key;
    logic [ValW-1:0]        r_value, n_value;

    logic                   r_res_found, n_res_found;
    logic [ValW-1:0]        r_res_value, n_res_value;
    logic [AW-1:0]          r_res_slot, n_res_slot;
    logic                   r_res_status, n_res_status;

    logic                   r_out_valid, n_out_valid;
    logic                   r_out_found, n_out_found;
    logic [ValW-1:0]        r_out_value, n_out_value;
    logic [AW-1:0]          r_out_slot, n_out_slot;
    logic                   r_out_status, n_out_status;

    logic [AW-1:0]          w_next_pos;
    logic [KeyPadW-1:0]     w_key_pad;
    logic [XW-1:0]          w_hx;
    logic [XW+MW-1:0]       w_hprod;
    logic [QW-1:0]          w_hq;
    logic [XW-1:0]          w_hqn;
    logic [XW-1:0]          w_hdiff;
    logic [AW-1:0]          w_raddr;
    logic                   w_used_we;
    logic                   w_used_wdata;
    logic                   w_kv_we;
    logic                   w_used_rd;
    logic [KeyW+ValW-1:0]   w_kv_rd;
    logic [KeyW-1:0]        w_rd_key;
    logic [ValW-1:0]        w_rd_value;
    logic                   w_accept;

    assign w_next_pos = (r_pos == LastSlot) ? '0 : r_pos + 1'b1;

    // Shift the next key byte into the remainder; quotient first, then subtract.
    assign w_key_pad = KeyPadW'(r_key);
    assign w_hx      = {r_rem, w_key_pad[r_hcnt*ChunkW +: ChunkW]};
    assign w_hprod   = {{MW{1'b0}}, w_hx} * {{XW{1'b0}}, RecipMul};
    assign w_hq      = w_hprod[RecipShift +: QW];
    assign w_hqn     = XW'(r_hq) * ModX;
    assign w_hdiff   = w_hx - w_hqn;

    assign w_rd_key   = w_kv_rd[KeyW+ValW-1:ValW];
    assign w_rd_value = w_kv_rd[ValW-1:0];

    assign w_accept = i_valid && o_ready;

    always_comb begin
        n_state      = r_state;
        n_pos        = r_pos;
        n_cnt        = r_cnt;
        n_rem        = r_rem;
        n_hcnt       = r_hcnt;
        n_hphase     = r_hphase;
        n_hq         = r_hq;
        n_op         = r_op;
        n_key        = r_key;
        n_value      = r_value;
        n_res_found  = r_res_found;
        n_res_value  = r_res_value;
        n_res_slot   = r_res_slot;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_out_found  = r_out_found;
        n_out_value  = r_out_value;
        n_out_slot   = r_out_slot;
        n_out_status = r_out_status;
        w_raddr      = w_next_pos;
        w_used_we    = 1'b0;
        w_used_wdata = 1'b0;
        w_kv_we      = 1'b0;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                w_used_we = 1'b1;
                n_pos     = w_next_pos;
                if (r_pos == LastSlot) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                w_raddr = i_key[AW-1:0];
                if (i_valid) begin
                    n_op    = i_op;
                    n_key   = i_key;
                    n_value = i_value;
                    n_cnt   = '0;
                    if (IsPow2) begin
                        n_pos   = i_key[AW-1:0];
                        n_state = S_PROBE;
                    end else begin
                        n_rem    = '0;
                        n_hcnt   = HcW'(NumChunks - 1);
                        n_hphase = 1'b0;
                        n_state  = S_HASH;
                    end
                end
            end
            S_HASH: begin
                if (!r_hphase) begin
                    n_hq     = w_hq;
                    n_hphase = 1'b1;
                end else begin
                    n_hphase = 1'b0;
                    n_rem    = w_hdiff[AW-1:0];
                    if (r_hcnt == '0) begin
                        w_raddr = w_hdiff[AW-1:0];
                        n_pos   = w_hdiff[AW-1:0];
                        n_state = S_PROBE;
                    end else begin
                        n_hcnt = r_hcnt - 1'b1;
                    end
                end
            end
            S_PROBE: begin
                n_res_found  = 1'b0;
                n_res_value  = '0;
                n_res_slot   = '0;
                n_res_status = ST_OK;
                if (r_op == OP_INSERT) begin
                    if (!w_used_rd) begin
                        w_used_we    = 1'b1;
                        w_used_wdata = 1'b1;
                        w_kv_we      = 1'b1;
                        n_res_slot   = r_pos;
                        n_state      = S_DONE;
                    end else if (r_cnt == LastSlot) begin
                        n_res_status = ST_FULL;
                        n_state      = S_DONE;
                    end else begin
                        n_pos = w_next_pos;
                        n_cnt = r_cnt + 1'b1;
                    end
                end else begin
                    if (!w_used_rd) begin
                        n_state = S_DONE;
                    end else if (w_rd_key == r_key) begin
                        n_res_found = 1'b1;
                        n_res_value = w_rd_value;
                        n_res_slot  = r_pos;
                        n_state     = S_DONE;
                    end else if (r_cnt == LastSlot) begin
                        n_state = S_DONE;
                    end else begin
                        n_pos = w_next_pos;
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            S_DONE: begin
                // Hold the result until the output register frees up.
                if (!r_out_valid || i_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_found  = r_res_found;
                    n_out_value  = r_res_value;
                    n_out_slot   = r_res_slot;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt        <= n_cnt;
        r_rem        <= n_rem;
        r_hcnt       <= n_hcnt;
        r_hphase     <= n_hphase;
        r_hq         <= n_hq;
        r_op         <= n_op;
        r_key        <= n_key;
        r_value      <= n_value;
        r_res_found  <= n_res_found;
        r_res_value  <= n_res_value;
        r_res_slot   <= n_res_slot;
        r_res_status <= n_res_status;
        r_out_found  <= n_out_found;
        r_out_value  <= n_out_value;
        r_out_slot   <= n_out_slot;
        r_out_status <= n_out_status;
    end

    lpht_ram #(
        .Width(1),
        .Depth(TABLE_SLOTS)
    ) u_used_ram (
        .i_clk  (i_clk),
        .i_we   (w_used_we),
        .i_waddr(r_pos),
        .i_wdata(w_used_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_used_rd)
    );

    lpht_ram #(
        .Width(KeyW + ValW),
        .Depth(TABLE_SLOTS)
    ) u_kv_ram (
        .i_clk  (i_clk),
        .i_we   (w_kv_we),
        .i_waddr(r_pos),
        .i_wdata({r_key, r_value}),
        .i_raddr(w_raddr),
        .o_rdata(w_kv_rd)
    );

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_found       = r_out_found;
    assign o_found_value = r_out_value;
    assign o_slot        = SlotW'(r_out_slot);
    assign o_status      = r_out_status;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_ready)
        else $error("block ready in the cycle after taking a request");

    a_hit_is_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_found |-> o_status == ST_OK)
        else $error("search hit reported together with table full");

    a_miss_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_found_value == '0)
        else $error("nonzero data on a result without a hit");

    a_write_only_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_kv_we |-> r_state == S_PROBE && r_op == OP_INSERT && !w_used_rd)
        else $error("table entry written outside an insert into a free slot");

    a_full_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_FULL |-> o_slot == '0 && !o_found)
        else $error("rejected insert reports a slot");

endmodule

### rtl/lpht_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lpht_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### verif/tb_linear_probe_hash_table.sv
// Testbench for the linear probing hash table: directed fill plus random lookups and inserts, scoreboarded.
module tb_linear_probe_hash_table;
    import lpht_pkg::*;

    localparam int TABLE_SLOTS = 16;
    localparam int RANDOM_REQUESTS = 950;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [KeyW-1:0] KEY_MAX = {KeyW{1'b1}};

    typedef struct packed {
        logic                   found;
        logic signed [ValW-1:0] found_value;
        logic [SlotW-1:0]       slot;
        logic                   status;
    } lookup_t;

    class hash_scoreboard;
        bit                     used [TABLE_SLOTS];
        logic [KeyW-1:0]        keys [TABLE_SLOTS];
        logic signed [ValW-1:0] vals [TABLE_SLOTS];
        lookup_t                expected_q [$];
        int                     errors = 0;

        // Walk the table exactly as the block does and queue the expected result.
        function void note_request(logic op, logic [KeyW-1:0] key,
                                   logic signed [ValW-1:0] value);
            lookup_t res;
            int      pos;
            res = '0;
            pos = key % TABLE_SLOTS;
            if (op == OP_INSERT) begin
                res.status = ST_FULL;
                for (int n = 0; n < TABLE_SLOTS; n++) begin
                    if (!used[pos]) begin
                        used[pos] = 1'b1;
                        keys[pos] = key;
                        vals[pos] = value;
                        res.slot = pos[SlotW-1:0];
                        res.status = ST_OK;
                        break;
                    end
                    pos = (pos + 1) % TABLE_SLOTS;
                end
            end else begin
                for (int n = 0; n < TABLE_SLOTS; n++) begin
                    if (!used[pos])
                        break;
                    if (keys[pos] == key) begin
                        res.found = 1'b1;
                        res.found_value = vals[pos];
                        res.slot = pos[SlotW-1:0];
                        break;
                    end
                    pos = (pos + 1) % TABLE_SLOTS;
                end
            end
            expected_q.push_back(res);
        endfunction

        function void check_result(lookup_t got);
            lookup_t exp;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result found=%0d value=%0d slot=%0d status=%0d",
                         $time, got.found, got.found_value, got.slot, got.status);
                errors++;
                return;
            end
            exp = expected_q.pop_front();
            if (got.found !== exp.found) begin
                $display("%0t: found expected %0d actual %0d", $time, exp.found, got.found);
                errors++;
            end
            if (got.found_value !== exp.found_value) begin
                $display("%0t: found_value expected %0d actual %0d",
                         $time, exp.found_value, got.found_value);
                errors++;
            end
            if (got.slot !== exp.slot) begin
                $display("%0t: slot expected %0d actual %0d", $time, exp.slot, got.slot);
                errors++;
            end
            if (got.status !== exp.status) begin
                $display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_ready;
    logic                   i_op;
    logic [KeyW-1:0]        i_key;
    logic signed [ValW-1:0] i_value;
    logic                   o_valid;
    logic                   i_ready;
    logic                   o_found;
    logic signed [ValW-1:0] o_found_value;
    logic [SlotW-1:0]       o_slot;
    logic                   o_status;

    hash_scoreboard sb;
    int req_calm = 0;
    int rsp_calm = 0;
    int stall_cycles = 0;
    bit rst_done = 1'b0;

    linear_probe_hash_table #(.TABLE_SLOTS(TABLE_SLOTS)) dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mostly short gaps, a few long ones, and now and then a stretch with none.
    function automatic int pick_gap(inout int calm_left);
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        if (r < 40)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_request(logic op, logic [KeyW-1:0] key, logic signed [ValW-1:0] value);
        int gap;
        gap = pick_gap(req_calm);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op    <= op;
        i_key   <= key;
        i_value <= value;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(op, key, value);
    endtask

    task automatic search_key(logic [KeyW-1:0] key);
        send_request(OP_SEARCH, key, $urandom());
    endtask

    // Result side: stall at random, check every accepted result.
    initial begin
        int gap;
        wait (rst_done);
        forever begin
            gap = pick_gap(rsp_calm);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            sb.check_result('{o_found, o_found_value, o_slot, o_status});
        end
    end

    // Count cycles in which neither side moves anything.
    initial begin
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int r;
        sb = new;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_ready <= 1'b0;
        i_op    <= OP_INSERT;
        i_key   <= '0;
        i_value <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        rst_done = 1'b1;

        // Directed: empty table, collisions, wraparound, duplicates, then fill to full.
        search_key('0);
        send_request(OP_INSERT, '0, 32'sh7FFF_FFFF);
        send_request(OP_INSERT, 31'd16, 32'sh8000_0000);
        send_request(OP_INSERT, KEY_MAX, 32'sd0);
        send_request(OP_INSERT, 31'd31, -32'sd1);
        search_key(31'd31);
        search_key(31'd47);
        send_request(OP_INSERT, 31'd16, 32'sh0000_1234);
        search_key(31'd16);
        search_key('0);
        search_key(KEY_MAX);
        // Pile the rest onto one home slot for long probe chains.
        for (int n = 0; n < 11; n++)
            send_request(OP_INSERT, (31'($urandom_range(1, 26'h3FF_FFFF)) << 4) | 31'd4,
                         $urandom());
        send_request(OP_INSERT, 31'd5, 32'sh5A5A_A5A5);
        search_key(31'h7FFF_FFEF);
        search_key(sb.keys[14]);

        // Random: table is full now, so mostly lookups of stored keys.
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            r = $urandom_range(0, 99);
            if (r < 55)
                search_key(sb.keys[$urandom_range(0, TABLE_SLOTS - 1)]);
            else if (r < 70)
                search_key(31'($urandom_range(0, 63)));
            else if (r < 85)
                search_key(31'($urandom()));
            else
                send_request(OP_INSERT, 31'($urandom()), $urandom());
        end
        i_valid <= 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### files.f
rtl/lpht_pkg.sv
rtl/lpht_ram.sv
rtl/linear_probe_hash_table.sv
verif/tb_linear_probe_hash_table.sv
